>>> rtl/rof_pkg.sv
package rof_pkg;

   // Geometry of the window and of the sorting chain.
   localparam int unsigned WIN_SIZE    = 9;
   localparam int unsigned SORT_STAGES = 9;
   localparam int unsigned PIX_W       = 8;
   localparam int unsigned RANK_W      = 4;

   // Widths of the configuration registers.
   localparam int unsigned PERCENT_W = 7;
   localparam int unsigned WIDTH_W   = 11;
   localparam int unsigned CSR_W     = 11;

   // Defaults after reset.
   localparam int unsigned DEF_MAX_WIDTH = 1024;
   localparam logic [PERCENT_W-1:0] PERCENT_RESET = 7'd50;
   localparam logic [WIDTH_W-1:0]   WIDTH_RESET   = 11'd640;
   localparam int unsigned MIN_WIDTH = 3;

   // Register indexes on the configuration port.
   localparam logic CSR_PERCENT = 1'b0;
   localparam logic CSR_WIDTH   = 1'b1;

   // Row counter saturates once two full rows are buffered.
   localparam logic [1:0] ROW_FULL = 2'd2;

   // Smallest percent that reaches rank k (k = 1 .. 8): ceil(100 * k / 9).
   localparam logic [PERCENT_W-1:0] RANK_STEP [8] = '{
      7'd12, 7'd23, 7'd34, 7'd45, 7'd56, 7'd67, 7'd78, 7'd89
   };

   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_type;

   // Tag that rides along with each window through the sorting chain.
   typedef struct packed {
      logic valid;
      logic row_end;
   } tag_type;

   // Control from the front end to the line buffer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lb_ctl_type;

   // One result waiting in the output queue.
   typedef struct packed {
      logic             row_end;
      logic [PIX_W-1:0] px;
   } res_type;

   // Rank floor(9 * percent / 100), clamped to 8, counted against thresholds.
   function automatic logic [RANK_W-1:0] rank_of(input logic [PERCENT_W-1:0] pct);
      logic [RANK_W-1:0] rank;
      rank = '0;
      for (int k = 0; k < 8; k++) begin
         if (pct >= RANK_STEP[k]) begin
            rank = rank + 1'b1;
         end
      end
      return rank;
   endfunction

   // Last column index for a given width, with the width clamped to 3 .. max.
   function automatic int unsigned last_col_of(input logic [WIDTH_W-1:0] w,
                                               input int unsigned maxw);
      int unsigned wi;
      wi = int'(w);
      if (wi < MIN_WIDTH) begin
         wi = MIN_WIDTH;
      end
      if (wi > maxw) begin
         wi = maxw;
      end
      return wi - 1;
   endfunction

endpackage

>>> rtl/rank_order_filter_3x3_top.sv
// 3x3 rank-order filter for 8-bit grey pixels in raster order.
// Input channel req_*: one pixel per request, req_tuser marks the first
// pixel of a frame. Result channel rsp_*: one filtered pixel per window
// that lies fully inside the image, rsp_tlast marks the last result of a
// cropped row; the output image is (width-2) x (height-2).
// Configuration csr_*: index 0 is the percent (50 gives the median),
// index 1 the row width, clamped to 3 .. MAX_WIDTH. Write only while idle.
// Throughput: one request per cycle while the output queue has room, set by
// the line buffers, which read one column and write another each cycle, and
// the nine-cell sorting chain that advances per cycle.
// A result passes from the line-buffer stage into the window registers,
// through the nine sort cells and into the output queue before it is visible.
// A two-entry output queue holds results while the receiver stalls; the
// pipeline keeps accepting requests until the queue is full, then
// req_tready drops and returns the cycle after a result is taken.
// Reset clears the row and column counters, the queue and all valid bits
// and loads percent 50 and width 640. The line buffers are not cleared.
module rank_order_filter_3x3_top #(
   parameter int unsigned MAX_WIDTH = rof_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input: [7:0] pixel
   input  logic [7:0]                    req_tdata,
   // Input: [0] frame_start
   input  logic                          req_tuser,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Output: [7:0] out_pixel
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [rof_pkg::CSR_W-1:0]     csr_wdata
);
   import rof_pkg::*;

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);

   // Configuration, kept in derived form.
   logic [RANK_W-1:0] rank_ff;
   logic [COL_W-1:0]  last_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff     <= rank_of(PERCENT_RESET);
         last_col_ff <= COL_W'(last_col_of(WIDTH_RESET, MAX_WIDTH));
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PERCENT: rank_ff <= rank_of(csr_wdata[PERCENT_W-1:0]);
            CSR_WIDTH:   last_col_ff <= COL_W'(last_col_of(csr_wdata[WIDTH_W-1:0],
                                                           MAX_WIDTH));
            default: ;
         endcase
      end
   end

   // Pipeline advances while the output queue has room.
   logic [1:0] q_count_ff;
   logic       en;
   logic       acc;

   assign en         = (q_count_ff != 2'd2);
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   // Column and row tracking at the accept point.
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [1:0]       row_ff;
   logic [1:0]       row_in;
   logic [COL_W-1:0] col_cur;
   logic [1:0]       row_cur;
   logic             is_last;
   logic             emit;

   always_comb begin
      col_cur = req_tuser ? '0 : col_ff;
      if (col_cur > last_col_ff) begin
         col_cur = '0;
      end
      row_cur = req_tuser ? 2'd0 : row_ff;
      is_last = (col_cur == last_col_ff);
      emit    = (row_cur == ROW_FULL) && (col_cur >= COL_W'(2));
      if (is_last) begin
         col_in = '0;
         row_in = (row_cur < ROW_FULL) ? row_cur + 2'd1 : row_cur;
      end else begin
         col_in = col_cur + COL_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= 2'd0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line-buffer stage: the request waits here for its column read.
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_px_ff   <= req_tdata;
         s1_col_ff  <= col_cur;
         s1_emit_ff <= emit;
         s1_last_ff <= is_last;
      end
   end

   lb_ctl_type       lb_ctl;
   logic [PIX_W-1:0] up1;
   logic [PIX_W-1:0] up2;

   assign lb_ctl.rd_en = acc;
   assign lb_ctl.wr_en = en && s1_valid_ff;

   rof_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .ctl     (lb_ctl),
      .rd_addr (col_cur),
      .wr_addr (s1_col_ff),
      .wr_px   (s1_px_ff),
      .up1     (up1),
      .up2     (up2)
   );

   // Window: each row shifts left, the new column enters on the right.
   win_type window_ff;
   logic    win_valid_ff;
   logic    win_row_end_ff;

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r*3+0] <= window_ff[r*3+1];
            window_ff[r*3+1] <= window_ff[r*3+2];
         end
         window_ff[2] <= up2;
         window_ff[5] <= up1;
         window_ff[8] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
      end else if (en) begin
         win_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_row_end_ff <= s1_last_ff;
      end
   end

   // Sorting chain: nine cells of alternating odd-even transposition.
   win_type chain_vals [SORT_STAGES+1];
   tag_type chain_tag  [SORT_STAGES+1];

   assign chain_vals[0] = window_ff;
   assign chain_tag[0]  = '{valid: win_valid_ff, row_end: win_row_end_ff};

   for (genvar k = 0; k < SORT_STAGES; k++) begin : g_sort
      rof_sort_cell #(
         .ODD ((k % 2) == 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vals  (chain_vals[k]),
         .in_tag   (chain_tag[k]),
         .out_vals (chain_vals[k+1]),
         .out_tag  (chain_tag[k+1])
      );
   end

   // Pick the requested rank from the sorted window.
   res_type new_res;
   logic    push;
   logic    pop;

   assign new_res.px      = chain_vals[SORT_STAGES][rank_ff];
   assign new_res.row_end = chain_tag[SORT_STAGES].row_end;
   assign push            = en && chain_tag[SORT_STAGES].valid;
   assign pop             = rsp_tvalid && rsp_tready;

   // Two-entry output queue; q0 is the head.
   res_type q0_ff;
   res_type q1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   q_count_ff <= q_count_ff + 2'd1;
            2'b01:   q_count_ff <= q_count_ff - 2'd1;
            default: q_count_ff <= q_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (q_count_ff == 2'd0) begin
               q0_ff <= new_res;
            end else begin
               q1_ff <= new_res;
            end
         end
         2'b01: begin
            q0_ff <= q1_ff;
         end
         2'b11: begin
            q0_ff <= new_res;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = (q_count_ff != 2'd0);
   assign rsp_tdata  = q0_ff.px;
   assign rsp_tlast  = q0_ff.row_end;

   // The queue never holds more than two results.
   assert property (@(posedge clock) disable iff (reset)
      q_count_ff != 2'd3)
      else $error("output queue count out of range");

   // After an accepted request, the next column stays inside the row.
   assert property (@(posedge clock) disable iff (reset)
      acc && !csr_we |=> col_ff <= last_col_ff)
      else $error("column counter ran past the row width");

   // The row counter saturates at two.
   assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd3)
      else $error("row counter out of range");

   // A pop and a push with a single entry leave exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      push && pop |=> q_count_ff == $past(q_count_ff))
      else $error("queue count changed on simultaneous push and pop");

endmodule

>>> rtl/rof_line_buf.sv
module rof_line_buf #(
   parameter int unsigned MAX_WIDTH = rof_pkg::DEF_MAX_WIDTH
) (
   input  logic                           clock,
   input  rof_pkg::lb_ctl_type            ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   input  logic [rof_pkg::PIX_W-1:0]      wr_px,
   output logic [rof_pkg::PIX_W-1:0]      up1,
   output logic [rof_pkg::PIX_W-1:0]      up2
);
   import rof_pkg::*;

   // Row one above (a) and two above (b) the current row.
   logic [PIX_W-1:0] mem_a [MAX_WIDTH];
   logic [PIX_W-1:0] mem_b [MAX_WIDTH];

   logic [PIX_W-1:0] rd_a_ff;
   logic [PIX_W-1:0] rd_b_ff;
   logic             hit_ff;
   logic [PIX_W-1:0] fwd_a_ff;
   logic [PIX_W-1:0] fwd_b_ff;

   // A read that meets a write to the same column takes the written data.
   assign up1 = hit_ff ? fwd_a_ff : rd_a_ff;
   assign up2 = hit_ff ? fwd_b_ff : rd_b_ff;

   // Memories: the older row moves down, the new pixel goes into row a.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_a[wr_addr] <= wr_px;
         mem_b[wr_addr] <= up1;
      end
      if (ctl.rd_en) begin
         rd_a_ff  <= mem_a[rd_addr];
         rd_b_ff  <= mem_b[rd_addr];
         hit_ff   <= ctl.wr_en && (wr_addr == rd_addr);
         fwd_a_ff <= wr_px;
         fwd_b_ff <= up1;
      end
   end

endmodule

>>> rtl/rof_sort_cell.sv
module rof_sort_cell #(
   parameter bit ODD = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  rof_pkg::win_type  in_vals,
   input  rof_pkg::tag_type  in_tag,
   output rof_pkg::win_type  out_vals,
   output rof_pkg::tag_type  out_tag
);
   import rof_pkg::*;

   win_type vals_in;
   win_type vals_ff;
   logic    tag_valid_ff;
   logic    tag_row_end_ff;

   // One round of odd-even transposition: independent compare-exchanges.
   always_comb begin
      vals_in = in_vals;
      for (int i = (ODD ? 1 : 0); i + 1 < WIN_SIZE; i += 2) begin
         if (in_vals[i] > in_vals[i+1]) begin
            vals_in[i]   = in_vals[i+1];
            vals_in[i+1] = in_vals[i];
         end
      end
   end

   // Tag valid needs reset; the pixel values do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else if (en) begin
         tag_valid_ff <= in_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vals_ff        <= vals_in;
         tag_row_end_ff <= in_tag.row_end;
      end
   end

   assign out_vals = vals_ff;
   assign out_tag  = '{valid: tag_valid_ff, row_end: tag_row_end_ff};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rof_pkg::*;

   localparam int unsigned MAX_W        = DEF_MAX_WIDTH;
   // Cycles to let pass after the last expected result: pipeline depth plus margin.
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned RANDOM_ITEMS = 850;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic             row_end;
   } filtered_px_type;

   // Predicts the filtered pixels from the accepted requests and checks the results.
   class rank_filter_scoreboard;
      logic [PERCENT_W-1:0] pct;
      logic [WIDTH_W-1:0]   width_reg;
      logic [PIX_W-1:0]     line_a [MAX_W];
      logic [PIX_W-1:0]     line_b [MAX_W];
      logic [PIX_W-1:0]     win_px [9];
      int unsigned          col_next;
      int unsigned          row_next;
      filtered_px_type      filtered_q [$];
      int unsigned          errors;

      function new();
         pct       = PERCENT_RESET;
         width_reg = WIDTH_RESET;
         for (int i = 0; i < MAX_W; i++) begin
            line_a[i] = '0;
            line_b[i] = '0;
         end
         for (int i = 0; i < 9; i++) begin
            win_px[i] = '0;
         end
         col_next = 0;
         row_next = 0;
         errors   = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      function int unsigned pending();
         return filtered_q.size();
      endfunction

      // Row width as the block uses it, held to 3 .. MAX_W.
      function int unsigned effective_width();
         int unsigned w;
         w = width_reg;
         if (w < MIN_WIDTH) begin
            w = MIN_WIDTH;
         end
         if (w > MAX_W) begin
            w = MAX_W;
         end
         return w;
      endfunction

      function void set_reg(logic idx, logic [CSR_W-1:0] value);
         if (idx == CSR_PERCENT) begin
            pct = value[PERCENT_W-1:0];
         end else begin
            width_reg = value[WIDTH_W-1:0];
         end
      endfunction

      // Sorts the window and picks rank floor(9 * percent / 100), held to 8.
      function logic [PIX_W-1:0] ranked_pixel();
         logic [PIX_W-1:0] s [9];
         logic [PIX_W-1:0] key;
         int               j;
         int unsigned      rank;
         s = win_px;
         for (int i = 1; i < 9; i++) begin
            key = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > key) begin
               s[j + 1] = s[j];
               j--;
            end
            s[j + 1] = key;
         end
         rank = (9 * int'(pct)) / 100;
         if (rank > 8) begin
            rank = 8;
         end
         return s[rank];
      endfunction

      function void note_request(logic [PIX_W-1:0] px, logic frame_start);
         int unsigned      w;
         int unsigned      c;
         logic [PIX_W-1:0] up1;
         logic [PIX_W-1:0] up2;
         filtered_px_type  res;
         w = effective_width();
         // A frame start puts this pixel at row 0, column 0.
         if (frame_start) begin
            col_next = 0;
            row_next = 0;
         end
         // A column beyond a lowered width wraps to the row start.
         if (col_next >= w) begin
            col_next = 0;
         end
         c   = col_next;
         up2 = line_b[c];
         up1 = line_a[c];
         // Shift the window one column left and load the new column.
         for (int r = 0; r < 3; r++) begin
            win_px[r * 3]     = win_px[r * 3 + 1];
            win_px[r * 3 + 1] = win_px[r * 3 + 2];
         end
         win_px[2] = up2;
         win_px[5] = up1;
         win_px[8] = px;
         line_b[c] = up1;
         line_a[c] = px;
         // Only windows fully inside the image give a result.
         if (row_next >= 2 && c >= 2) begin
            res.px      = ranked_pixel();
            res.row_end = (c == w - 1);
            filtered_q.push_back(res);
         end
         if (c == w - 1) begin
            col_next = 0;
            if (row_next < 2) begin
               row_next++;
            end
         end else begin
            col_next = c + 1;
         end
      endfunction

      task check_result(logic [PIX_W-1:0] px, logic row_end);
         filtered_px_type exp_px;
         if (filtered_q.size() == 0) begin
            report($sformatf("result px=%0d row_end=%0b with none expected", px, row_end));
            return;
         end
         exp_px = filtered_q.pop_front();
         if (px !== exp_px.px) begin
            report($sformatf("pixel %0d, expected %0d", px, exp_px.px));
         end
         if (row_end !== exp_px.row_end) begin
            report($sformatf("row end %0b, expected %0b", row_end, exp_px.row_end));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic [7:0]       req_tdata;
   logic             req_tuser;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic             csr_we;
   logic             csr_addr;
   logic [CSR_W-1:0] csr_wdata;

   rank_filter_scoreboard sb;
   int unsigned sent_count = 0;
   int unsigned stim_w     = WIDTH_RESET;
   int unsigned send_idle  = 23;
   int unsigned take_idle  = 23;
   int unsigned rsp_hold   = 0;

   rank_order_filter_3x3_top #(
      .MAX_WIDTH(MAX_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= take_idle);
         end
      end
   end

   // Check every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'd120 + 8'($urandom_range(0, 15));
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one pixel request, with random gaps, and wait for it to be taken.
   task automatic send_pixel(input logic [7:0] px, input logic frame_start);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= px;
      req_tuser  <= frame_start;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(px, frame_start);
      sent_count++;
      @(negedge clock);
   endtask

   // Stop sending and wait until the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   // Width write; a wider row must begin with a new frame.
   task automatic write_width(input int unsigned w, output bit needs_frame);
      write_reg(CSR_WIDTH, CSR_W'(w));
      needs_frame = (sb.effective_width() > stim_w);
      stim_w      = sb.effective_width();
   endtask

   // A frame of whole rows, optionally cut short, with optional stray frame starts.
   task automatic send_frame(input int unsigned rows, input int unsigned cut,
                             input bit with_fs, input bit noisy);
      int unsigned total;
      logic        fs;
      total = rows * stim_w;
      if (cut != 0 && cut < total) begin
         total = cut;
      end
      for (int unsigned k = 0; k < total; k++) begin
         fs = (k == 0) ? with_fs : (noisy && $urandom_range(0, 199) == 0);
         send_pixel(rand_pixel(), fs);
      end
   endtask

   initial begin
      int unsigned target;
      int unsigned nf;
      int unsigned rows;
      int unsigned cut;
      logic [PERCENT_W-1:0] new_pct;
      bit need_fs;
      bit with_fs;

      sb         = new();
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tvalid = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_PERCENT;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Width below the minimum, lowest rank, extreme pixel values.
      write_width(2, need_fs);
      write_reg(CSR_PERCENT, CSR_W'(0));
      for (int i = 0; i < 12; i++) begin
         send_pixel(8'(i * 85), i == 0);
      end
      settle();

      // Percent above 100 behaves as 100.
      write_reg(CSR_PERCENT, CSR_W'(127));
      for (int i = 0; i < 4; i++) begin
         send_pixel((i % 2 == 0) ? 8'hFF : 8'h01, 1'b0);
      end
      settle();

      // Frame start in the middle of a row, highest rank.
      write_reg(CSR_PERCENT, CSR_W'(100));
      for (int i = 0; i < 9; i++) begin
         send_pixel(8'(255 - i * 31), i == 0);
      end
      settle();

      // Receiver holds off for a long stretch so the block fills and stalls.
      write_width(8, need_fs);
      write_reg(CSR_PERCENT, CSR_W'(50));
      rsp_hold = 400;
      send_frame(12, 0, 1'b1, 1'b0);
      settle();

      // A stretch with no idling on either side.
      send_idle = 0;
      take_idle = 0;
      write_width(12, need_fs);
      write_reg(CSR_PERCENT, CSR_W'($urandom_range(0, 127)));
      send_frame(6, 0, 1'b1, 1'b0);
      settle();
      send_idle = 23;
      take_idle = 23;

      // Widest row, then a width past the maximum; the first row only counts columns.
      write_width(MAX_W, need_fs);
      write_reg(CSR_PERCENT, CSR_W'($urandom_range(0, 100)));
      send_frame(1, 120, 1'b1, 1'b0);
      settle();
      write_width(2047, need_fs);
      for (int unsigned k = 0; k < 60; k++) begin
         send_pixel(rand_pixel(), 1'b0);
      end
      settle();
      write_width(8, need_fs);

      // Random phases: new settings, then a few frames of random content.
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         case ($urandom_range(0, 4))
            0: new_pct = 0;
            1: new_pct = 100;
            2: new_pct = 127;
            3: new_pct = 50;
            default: new_pct = PERCENT_W'($urandom_range(0, 127));
         endcase
         write_reg(CSR_PERCENT, CSR_W'(new_pct));
         need_fs = 1'b0;
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: write_width($urandom_range(0, 2), need_fs);
               1: write_width($urandom_range(17, 48), need_fs);
               default: write_width($urandom_range(3, 16), need_fs);
            endcase
         end
         nf = $urandom_range(1, 3);
         for (int unsigned f = 0; f < nf; f++) begin
            // Continuing without a frame start is allowed unless the row grew.
            if (f == 0) begin
               with_fs = need_fs || ($urandom_range(0, 3) != 0);
            end else begin
               with_fs = ($urandom_range(0, 9) != 0);
            end
            rows = $urandom_range(3, 5);
            cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, rows * stim_w) : 0;
            send_frame(rows, cut, with_fs, 1'b1);
         end
         settle();
      end

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> rank_order_filter_3x3_top.f
rtl/rof_pkg.sv
rtl/rof_line_buf.sv
rtl/rof_sort_cell.sv
rtl/rank_order_filter_3x3_top.sv
bench/testbench.sv
